@@ sv/pkva_pkg.sv @@
// ----------------------------------------------------------------------------
// pkva_pkg: shared types and constants of the paged KV page allocator
// Widths, command and status codes, queue item, slot record and divider
// request/response groups.
// ----------------------------------------------------------------------------
package pkva_pkg;

  localparam int NUM_PAGES   = 1024;
  localparam int MAX_HANDLES = 64;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int SLOT_W      = $clog2(MAX_HANDLES);
  localparam int SCAN_W      = $clog2(MAX_HANDLES + 1);
  localparam int CNT_W       = 11;
  localparam int TAG_W       = 32;
  localparam int AGENT_W     = 16;
  localparam int BYTES_W     = 41;
  localparam int PB_W        = 25;
  localparam int USED_W      = 35;
  localparam int DIV_W       = 42;
  localparam int DCNT_W      = $clog2(DIV_W + 1);

  localparam logic [PB_W-1:0]   MIN_PAGE    = PB_W'(4096);
  localparam logic [SCAN_W-1:0] SCAN_END    = SCAN_W'(MAX_HANDLES);
  localparam logic [CNT_W-1:0]  POOL_LIMIT  = CNT_W'(NUM_PAGES);

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_ENSURE  = 3'd2,
    CMD_TRIM    = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_QUERY   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FILL, S_CSCAN, S_FRD, S_FCMP, S_SWAIT,
    S_GROW_RD, S_GROW_WR, S_TRIM_RD, S_TRIM_WR, S_SAVE, S_MUL, S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [TAG_W-1:0]   handle;
    logic [AGENT_W-1:0] agent;
    logic [BYTES_W-1:0] bytes;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [AGENT_W-1:0] owner;
    logic [PAGE_W-1:0]  top;
    logic [PAGE_W-1:0]  bottom;
    logic [CNT_W-1:0]   count;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PB_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/pkva_front.sv @@
// ----------------------------------------------------------------------------
// pkva_front: command intake
// Accepts items, maps the command onto an operation and holds them in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module pkva_front import pkva_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic [TAG_W-1:0]   handle,
  input  logic [AGENT_W-1:0] agent,
  input  logic [BYTES_W-1:0] bytes,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       accept;
  op_t        op_dec;

  // unused codes behave as query
  always_comb begin
    unique case (command)
      3'd0:    op_dec = CMD_INIT;
      3'd1:    op_dec = CMD_CREATE;
      3'd2:    op_dec = CMD_ENSURE;
      3'd3:    op_dec = CMD_TRIM;
      3'd4:    op_dec = CMD_RELEASE;
      default: op_dec = CMD_QUERY;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = ent[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      ent[wr_ptr] <= '{op: op_dec, handle: handle, agent: agent, bytes: bytes};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (q_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(accept) - 2'(q_pop);
    end
  end

endmodule

@@ sv/pkva_div.sv @@
// ----------------------------------------------------------------------------
// pkva_div: restoring divider
// One quotient bit per cycle; used for pool sizing and page rounding.
// ----------------------------------------------------------------------------
module pkva_div import pkva_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [PB_W-1:0]   divisor;
  logic [PB_W-1:0]   rem;
  logic [DIV_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [PB_W:0]     trial;
  logic [PB_W:0]     diff;
  logic              ge;

  // one trial subtraction
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    ge    = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      quo     <= req.dividend;
      rem     <= '0;
    end else if (busy) begin
      rem <= ge ? diff[PB_W-1:0] : trial[PB_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ sv/pkva_back.sv @@
// ----------------------------------------------------------------------------
// pkva_back: execution engine
// Sequencer over the page link memory, the slot memory and the divider;
// walks slots and moves pages one at a time, then registers the result.
// ----------------------------------------------------------------------------
module pkva_back import pkva_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [PB_W-1:0]     page_size_cfg,
  input  logic [BYTES_W-1:0]  pool_size_cfg,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [TAG_W-1:0]    new_handle,
  output logic [CNT_W-1:0]    handle_pages,
  output logic [CNT_W-1:0]    free_page_count,
  output logic [USED_W-1:0]   used_size
);

  state_t state, state_next;

  // architectural state
  logic [PAGE_W-1:0]      free_top;
  logic [CNT_W-1:0]       free_count;
  logic [CNT_W-1:0]       pool_pages;
  logic [TAG_W-1:0]       handle_counter;
  logic [MAX_HANDLES-1:0] slot_valid;

  // working registers
  item_t             cur;
  slot_t             sd;
  logic [SCAN_W-1:0] scan_idx;
  logic [CNT_W-1:0]  fill_k;
  logic [CNT_W-1:0]  add_cnt;
  logic [CNT_W-1:0]  keep;
  status_t           res_status;
  logic [TAG_W-1:0]  res_newh;
  logic [CNT_W-1:0]  res_hp;
  logic [USED_W-1:0] prod;

  // memories
  logic [PAGE_W-1:0] link_mem [NUM_PAGES];
  logic [PAGE_W-1:0] link_rd;
  slot_t             slot_mem [MAX_HANDLES];
  slot_t             slot_rd;

  // memory ports and strobes
  logic              link_we;
  logic [PAGE_W-1:0] link_waddr;
  logic [PAGE_W-1:0] link_wdata;
  logic [PAGE_W-1:0] link_raddr;
  logic              slot_we;
  slot_t             slot_wdata;
  logic [SLOT_W-1:0] sidx;
  div_req_t          dreq;
  div_rsp_t          drsp;
  logic              out_load;

  // derived values
  logic [PB_W-1:0]   ps;
  logic [DIV_W-1:0]  q_cnt;
  logic [DIV_W-1:0]  q_need;
  logic [CNT_W-1:0]  diff_pages;
  logic [USED_W:0]   mul_full;
  logic              hit;

  assign ps     = (page_size_cfg < MIN_PAGE) ? MIN_PAGE : page_size_cfg;
  assign sidx   = scan_idx[SLOT_W-1:0];
  assign q_cnt  = DIV_W'(sd.count);
  assign q_need = drsp.quotient;
  assign hit    = slot_valid[sidx] && (slot_rd.tag == cur.handle);
  assign diff_pages = (pool_pages >= free_count) ? (pool_pages - free_count) : '0;
  assign mul_full   = {{PB_W{1'b0}}, diff_pages} * {{CNT_W{1'b0}}, ps};
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);

  pkva_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // next state, memory strobes, divider start
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    link_we    = 1'b0;
    link_waddr = free_top;
    link_wdata = sd.top;
    link_raddr = free_top;
    slot_we    = 1'b0;
    slot_wdata = sd;
    dreq.start    = 1'b0;
    dreq.dividend = DIV_W'(pool_size_cfg);
    dreq.divisor  = ps;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          priority case (q_item.op)
            CMD_INIT: begin
              dreq.start = 1'b1;
              state_next = S_DIV;
            end
            CMD_CREATE: state_next = S_CSCAN;
            default:    state_next = S_FRD;
          endcase
        end
      end
      S_DIV: begin
        if (drsp.done) state_next = S_FILL;
      end
      S_FILL: begin
        if (fill_k == pool_pages) begin
          state_next = S_MUL;
        end else begin
          link_we    = 1'b1;
          link_waddr = fill_k[PAGE_W-1:0];
          link_wdata = (fill_k == '0) ? '0 : PAGE_W'(fill_k - 1'b1);
        end
      end
      S_CSCAN: begin
        if (scan_idx == SCAN_END) begin
          state_next = S_MUL;
        end else if (!slot_valid[sidx]) begin
          slot_we    = 1'b1;
          slot_wdata = '{tag: handle_counter, owner: cur.agent, top: '0,
                         bottom: '0, count: '0};
          state_next = S_MUL;
        end
      end
      S_FRD: begin
        state_next = (scan_idx == SCAN_END) ? S_MUL : S_FCMP;
      end
      S_FCMP: begin
        if (!hit) begin
          state_next = S_FRD;
        end else begin
          unique case (cur.op)
            CMD_ENSURE, CMD_TRIM: begin
              dreq.start    = 1'b1;
              dreq.dividend = DIV_W'(cur.bytes) + DIV_W'(ps) - DIV_W'(1);
              state_next    = S_SWAIT;
            end
            CMD_RELEASE: begin
              link_we    = (slot_rd.count != '0);
              link_waddr = slot_rd.bottom;
              link_wdata = free_top;
              state_next = S_MUL;
            end
            default: state_next = S_MUL;
          endcase
        end
      end
      S_SWAIT: begin
        if (drsp.done) begin
          if (cur.op == CMD_ENSURE) begin
            if (q_need > q_cnt && DIV_W'(free_count) >= q_need - q_cnt) begin
              state_next = S_GROW_RD;
            end else begin
              state_next = S_MUL;
            end
          end else begin
            state_next = (q_cnt > q_need) ? S_TRIM_RD : S_MUL;
          end
        end
      end
      S_GROW_RD: begin
        link_raddr = free_top;
        state_next = S_GROW_WR;
      end
      S_GROW_WR: begin
        link_we    = 1'b1;
        link_waddr = free_top;
        link_wdata = sd.top;
        state_next = (add_cnt == CNT_W'(1)) ? S_SAVE : S_GROW_RD;
      end
      S_TRIM_RD: begin
        link_raddr = sd.top;
        state_next = S_TRIM_WR;
      end
      S_TRIM_WR: begin
        link_we    = 1'b1;
        link_waddr = sd.top;
        link_wdata = free_top;
        state_next = (sd.count - 1'b1 == keep) ? S_SAVE : S_TRIM_RD;
      end
      S_SAVE: begin
        slot_we    = 1'b1;
        slot_wdata = sd;
        state_next = S_MUL;
      end
      S_MUL:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // page link memory
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd <= link_mem[link_raddr];
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[sidx] <= slot_wdata;
    slot_rd <= slot_mem[sidx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top       <= '0;
      free_count     <= '0;
      pool_pages     <= '0;
      handle_counter <= '0;
      slot_valid     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_DIV: begin
          if (drsp.done) begin
            pool_pages <= (drsp.quotient > DIV_W'(NUM_PAGES)) ? POOL_LIMIT
                                                               : CNT_W'(drsp.quotient);
          end
        end
        S_FILL: begin
          if (fill_k == pool_pages) begin
            free_top   <= (pool_pages == '0) ? '0 : PAGE_W'(pool_pages - 1'b1);
            free_count <= pool_pages;
            slot_valid <= '0;
          end
        end
        S_CSCAN: begin
          if (scan_idx != SCAN_END && !slot_valid[sidx]) begin
            slot_valid[sidx] <= 1'b1;
            handle_counter   <= handle_counter + 1'b1;
          end
        end
        S_FCMP: begin
          if (hit && cur.op == CMD_RELEASE) begin
            slot_valid[sidx] <= 1'b0;
            if (slot_rd.count != '0) begin
              free_top   <= slot_rd.top;
              free_count <= free_count + slot_rd.count;
            end
          end
        end
        S_GROW_WR: begin
          free_top   <= link_rd;
          free_count <= free_count - 1'b1;
        end
        S_TRIM_WR: begin
          free_top   <= sd.top;
          free_count <= free_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur        <= q_item;
        scan_idx   <= '0;
        fill_k     <= '0;
        res_status <= ST_OK;
        res_newh   <= '0;
        res_hp     <= '0;
      end
      S_FILL: begin
        if (fill_k != pool_pages) fill_k <= fill_k + 1'b1;
      end
      S_CSCAN: begin
        if (scan_idx == SCAN_END) begin
          res_status <= ST_FULL;
        end else if (!slot_valid[sidx]) begin
          res_newh <= handle_counter;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      S_FRD: begin
        if (scan_idx == SCAN_END && cur.op != CMD_QUERY) res_status <= ST_UNKNOWN;
      end
      S_FCMP: begin
        if (!hit) begin
          scan_idx <= scan_idx + 1'b1;
        end else begin
          sd <= slot_rd;
          if (cur.op == CMD_QUERY) res_hp <= slot_rd.count;
        end
      end
      S_SWAIT: begin
        if (drsp.done) begin
          res_hp  <= sd.count;
          add_cnt <= CNT_W'(q_need - q_cnt);
          keep    <= CNT_W'(q_need);
          if (cur.op == CMD_ENSURE && q_need > q_cnt &&
              DIV_W'(free_count) < q_need - q_cnt) begin
            res_status <= ST_NOSPACE;
          end
        end
      end
      S_GROW_WR: begin
        if (sd.count == '0) sd.bottom <= free_top;
        sd.top  <= free_top;
        sd.count <= sd.count + 1'b1;
        add_cnt <= add_cnt - 1'b1;
      end
      S_TRIM_WR: begin
        sd.top   <= link_rd;
        sd.count <= sd.count - 1'b1;
      end
      S_SAVE: res_hp <= sd.count;
      S_MUL:  prod   <= mul_full[USED_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      new_handle      <= res_newh;
      handle_pages    <= res_hp;
      free_page_count <= free_count;
      used_size       <= prod;
    end
  end

endmodule

@@ sv/paged_kv_page_allocator.sv @@
// ----------------------------------------------------------------------------
// paged_kv_page_allocator: page pool allocator for a paged KV cache
// Intake queue, configuration registers and execution engine.
// ----------------------------------------------------------------------------
// Items are taken into a two-entry queue and executed one at a time by a
// sequencer, so the input side keeps accepting, until the queue is full, while a result waits.
// Steps per item, from leaving the queue to the result register: init
// waits on the divider, then writes one page link per cycle; create scans
// for the first free slot, up to the end of the table when it is full;
// ensure, trim, release and query walk the slot memory for the handle;
// ensure and trim then wait on a rounding division, move pages one at a
// time through the registered-read link memory and write the slot back
// when pages move. There is no clearing pass after reset; slot valid bits
// are flip-flops.
// ----------------------------------------------------------------------------
module paged_kv_page_allocator import pkva_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  input  logic [TAG_W-1:0]    handle,
  input  logic [AGENT_W-1:0]  agent,
  input  logic [BYTES_W-1:0]  bytes,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [TAG_W-1:0]    new_handle,
  output logic [CNT_W-1:0]    handle_pages,
  output logic [CNT_W-1:0]    free_page_count,
  output logic [USED_W-1:0]   used_size,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [BYTES_W-1:0]  cfg_data
);

  logic [PB_W-1:0]    page_size_cfg;
  logic [BYTES_W-1:0] pool_size_cfg;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_cfg <= PB_W'(4096);
      pool_size_cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) page_size_cfg <= cfg_data[PB_W-1:0];
      else                   pool_size_cfg <= cfg_data;
    end
  end

  pkva_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .handle   (handle),
    .agent    (agent),
    .bytes    (bytes),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pkva_back u_back (
    .clk             (clk),
    .rst             (rst),
    .page_size_cfg   (page_size_cfg),
    .pool_size_cfg   (pool_size_cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .new_handle      (new_handle),
    .handle_pages    (handle_pages),
    .free_page_count (free_page_count),
    .used_size       (used_size)
  );

endmodule
